### design/vipf_pkg.sv
// Shared types and constants for the VLAN / IPv4 range packet filter.
// Used by vipf_rule_mem and vlan_ip_range_packet_filter; no dependencies.
`default_nettype none

package vipf_pkg;

  // Command codes carried in the input tuser
  localparam logic [1:0] CMD_FRAME  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_PASS    = 3'd0;
  localparam logic [2:0] ST_DROP    = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_STORED  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_VLAN = 16'h8100;

  // Byte positions within the frame
  localparam logic [5:0] POS_LIMIT    = 6'd63;
  localparam logic [5:0] POS_TYPE_HI  = 6'd12;
  localparam logic [5:0] POS_TYPE_LO  = 6'd13;
  localparam logic [5:0] POS_TAG_HI   = 6'd14;
  localparam logic [5:0] POS_TAG_LO   = 6'd15;
  localparam logic [5:0] POS_IPV4_SRC = 6'd26;
  localparam logic [5:0] POS_VLAN_SRC = 6'd30;
  localparam logic [5:0] ADDR_BYTES   = 6'd4;

  // Minimum frame lengths
  localparam logic [5:0] LEN_HEADER = 6'd14;
  localparam logic [5:0] LEN_IPV4   = 6'd34;
  localparam logic [5:0] LEN_VLAN   = 6'd38;

  typedef enum logic [1:0] {
    S_IDLE,
    S_JUDGE,
    S_READ,
    S_CMP
  } state_t;

  typedef struct packed {
    logic [15:0] vlan;
    logic [31:0] lo_addr;
    logic [31:0] hi_addr;
  } rule_t;

endpackage

`default_nettype wire

### design/vlan_ip_range_packet_filter.sv
// VLAN / IPv4 address range packet filter, top level.
// A command's result is registered in the cycle after the word is taken; a final
// byte's verdict without a walk (empty table, short frame, other ethertype) comes
// from S_JUDGE. Words are taken one per cycle while idle and the output is free;
// a walking final byte costs one table read and up to four comparator steps per rule.
// Reset clears the frame parser and the rule count; table contents are left as they are.
`default_nettype none

module vlan_ip_range_packet_filter
  import vipf_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] frame_byte, [23:8] new_rule_vlan, [55:24] new_rule_start,
  // [87:56] new_rule_end
  input  wire logic [87:0] in_tdata,
  // [1:0] command, [2] first_of_frame
  input  wire logic [2:0]  in_tuser,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] seen_vlan
  output logic [15:0]      out_tdata,
  // [2:0] status
  output logic [2:0]       out_tuser
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  state_t state_r, state_nxt;

  logic [5:0]  pos_r, pos_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] vlan_r, vlan_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [1:0]       step_r, step_nxt;
  logic             lo_ok_r, lo_ok_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [15:0] out_vlan_r, out_vlan_nxt;

  logic       in_acc, out_free, first, table_full;
  logic [1:0] cmd;
  rule_t      new_rule, rule_rd;

  logic        emit, mem_we;
  logic [2:0]  emit_status;
  logic [15:0] emit_vlan;

  // Frame parser next values
  logic [5:0]  cur_pos, base;
  logic [15:0] cur_type, cur_vlan;
  logic [31:0] cur_src, cur_dst;
  logic        has_base;
  logic [7:0]  fbyte;

  // Verdict and walk
  logic        judge_done, last_rule, vlan_ok, rule_hit, rule_end, cmp_le;
  logic [2:0]  judge_status;
  logic [15:0] seen_vlan;
  logic [31:0] cmp_a, cmp_b;

  assign cmd        = in_tuser[1:0];
  assign first      = in_tuser[2];
  assign fbyte      = in_tdata[7:0];
  assign out_free   = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign table_full = (count_r == CNT_W'(MAX_RULES));
  assign new_rule   = '{vlan: in_tdata[23:8], lo_addr: in_tdata[55:24],
                        hi_addr: in_tdata[87:56]};

  vipf_rule_mem #(
    .DEPTH (MAX_RULES),
    .AW    (IDX_W)
  ) u_rule_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (new_rule),
    .raddr (k_r),
    .rdata (rule_rd)
  );

  // Byte parser: restart on the first-of-frame mark, then take one byte
  always_comb begin
    cur_pos  = first ? '0 : pos_r;
    cur_type = first ? '0 : type_r;
    cur_vlan = first ? '0 : vlan_r;
    cur_src  = first ? '0 : src_r;
    cur_dst  = first ? '0 : dst_r;
    base     = '0;
    has_base = 1'b0;
    if (cur_pos >= POS_TAG_HI) begin
      if (cur_type == TYPE_IPV4) begin
        base     = POS_IPV4_SRC;
        has_base = 1'b1;
      end else if (cur_type == TYPE_VLAN) begin
        base     = POS_VLAN_SRC;
        has_base = 1'b1;
      end
    end

    type_nxt = cur_type;
    vlan_nxt = cur_vlan;
    src_nxt  = cur_src;
    dst_nxt  = cur_dst;
    if (cur_pos == POS_TYPE_HI || cur_pos == POS_TYPE_LO) begin
      type_nxt = {cur_type[7:0], fbyte};
    end
    if (cur_type == TYPE_VLAN && (cur_pos == POS_TAG_HI || cur_pos == POS_TAG_LO)) begin
      vlan_nxt = {cur_vlan[7:0], fbyte};
    end
    if (has_base) begin
      if (cur_pos >= base && cur_pos < base + ADDR_BYTES) begin
        src_nxt = {cur_src[23:0], fbyte};
      end else if (cur_pos >= base + ADDR_BYTES &&
                   cur_pos < base + ADDR_BYTES + ADDR_BYTES) begin
        dst_nxt = {cur_dst[23:0], fbyte};
      end
    end
    pos_nxt = (cur_pos < POS_LIMIT) ? cur_pos + 6'd1 : cur_pos;

    // Hold the frame unless a frame byte is taken
    if (!(in_acc && cmd == CMD_FRAME)) begin
      pos_nxt  = pos_r;
      type_nxt = type_r;
      vlan_nxt = vlan_r;
      src_nxt  = src_r;
      dst_nxt  = dst_r;
    end
  end

  // Verdicts settled without walking the table
  assign seen_vlan = (type_r == TYPE_VLAN) ? vlan_r : 16'd0;

  always_comb begin
    judge_done   = 1'b1;
    judge_status = ST_PASS;
    if (count_r == '0) begin
      judge_status = ST_PASS;
    end else if (pos_r < LEN_HEADER) begin
      judge_status = ST_SHORT;
    end else if (type_r == TYPE_IPV4) begin
      if (pos_r < LEN_IPV4) begin
        judge_status = ST_SHORT;
      end else begin
        judge_done = 1'b0;
      end
    end else if (type_r == TYPE_VLAN) begin
      if (pos_r < LEN_VLAN) begin
        judge_status = ST_SHORT;
      end else begin
        judge_done = 1'b0;
      end
    end else begin
      judge_status = ST_DROP;
    end
  end

  // Shared comparator: start<=src, src<=end, start<=dst, dst<=end
  always_comb begin
    case (step_r)
      2'd0: begin
        cmp_a = rule_rd.lo_addr;
        cmp_b = src_r;
      end
      2'd1: begin
        cmp_a = src_r;
        cmp_b = rule_rd.hi_addr;
      end
      2'd2: begin
        cmp_a = rule_rd.lo_addr;
        cmp_b = dst_r;
      end
      default: begin
        cmp_a = dst_r;
        cmp_b = rule_rd.hi_addr;
      end
    endcase
  end

  assign cmp_le    = (cmp_a <= cmp_b);
  assign vlan_ok   = (rule_rd.vlan == 16'd0) || (rule_rd.vlan == vlan_r);
  assign rule_hit  = vlan_ok &&
                     ((step_r == 2'd0 && rule_rd.lo_addr == 32'd0) ||
                      ((step_r == 2'd1 || step_r == 2'd3) && lo_ok_r && cmp_le));
  assign rule_end  = !vlan_ok || (step_r == 2'd3);
  assign last_rule = (CNT_W'(k_r) + CNT_W'(1)) == count_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && cmd == CMD_FRAME && in_tlast) begin
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        if (out_free) begin
          state_nxt = judge_done ? S_IDLE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (out_free) begin
          if (rule_hit) begin
            state_nxt = S_IDLE;
          end else if (rule_end) begin
            state_nxt = last_rule ? S_IDLE : S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready   = 1'b0;
    emit        = 1'b0;
    emit_status = ST_PASS;
    emit_vlan   = 16'd0;
    mem_we      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = out_free;
        if (in_acc) begin
          case (cmd)
            CMD_APPEND: begin
              emit        = 1'b1;
              emit_status = table_full ? ST_FULL : ST_STORED;
              mem_we      = !table_full;
            end
            CMD_CLEAR: begin
              emit        = 1'b1;
              emit_status = ST_CLEARED;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_JUDGE: begin
        if (out_free && judge_done) begin
          emit        = 1'b1;
          emit_status = judge_status;
          emit_vlan   = seen_vlan;
        end
      end
      S_CMP: begin
        if (out_free && (rule_hit || (rule_end && last_rule))) begin
          emit        = 1'b1;
          emit_status = rule_hit ? ST_PASS : ST_DROP;
          emit_vlan   = seen_vlan;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Walk counters, rule count and output word
  always_comb begin
    count_nxt = count_r;
    if (in_acc && cmd == CMD_APPEND && !table_full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (in_acc && cmd == CMD_CLEAR) begin
      count_nxt = '0;
    end

    k_nxt     = k_r;
    step_nxt  = '0;
    lo_ok_nxt = lo_ok_r;
    if (state_r == S_JUDGE) begin
      k_nxt = '0;
    end else if (state_r == S_CMP && out_free) begin
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd0 || step_r == 2'd2) begin
        lo_ok_nxt = cmp_le;
      end
      if (rule_end && !rule_hit) begin
        k_nxt = k_r + IDX_W'(1);
      end
    end else if (state_r == S_CMP) begin
      step_nxt = step_r;
    end

    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_vlan_nxt   = out_vlan_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = emit_status;
      out_vlan_nxt   = emit_vlan;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      type_r      <= '0;
      vlan_r      <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      type_r      <= type_nxt;
      vlan_r      <= vlan_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    step_r       <= step_nxt;
    lo_ok_r      <= lo_ok_nxt;
    out_status_r <= out_status_nxt;
    out_vlan_r   <= out_vlan_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_vlan_r;

  // The walk only ever compares stored rules
  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (CNT_W'(k_r) < count_r))
    else $error("rule walk beyond stored rules");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RULES))
    else $error("rule count above table depth");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[1:0] == CMD_CLEAR) |=> (count_r == '0))
    else $error("clear left rules in the table");

  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[1:0] == CMD_APPEND && !table_full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not advance rule count");

endmodule

`default_nettype wire

### design/vipf_rule_mem.sv
// Rule table storage: one write port, one read port with registered data.
// Depends on vipf_pkg for the rule_t entry layout.
`default_nettype none

module vipf_rule_mem
  import vipf_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire rule_t         wdata,
  input  wire logic [AW-1:0] raddr,
  output rule_t              rdata
);

  rule_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
